### rtl/core/msvs_pkg.sv
// ----------------------------------------------------------------------------
// msvs_pkg
// Shared types and constants of the memory snapshot value scanner.
// ----------------------------------------------------------------------------
package msvs_pkg;

  // fixed field widths
  localparam int unsigned ByteW       = 8;
  localparam int unsigned NibbleW     = 4;
  localparam int unsigned WordW       = 32;
  localparam int unsigned WindowW     = 24;
  localparam int unsigned MaskW       = 8;
  localparam int unsigned CfgIndexW   = 3;
  localparam int unsigned MatchW      = 32;
  localparam int unsigned DefAddrW    = 32;

  // operand masks per view width
  localparam logic [WordW-1:0] ByteMask = 32'h0000_00FF;
  localparam logic [WordW-1:0] HalfMask = 32'h0000_FFFF;
  localparam logic [WordW-1:0] FullMask = 32'hFFFF_FFFF;

  // value view codes; code 7 is reserved and never matches
  typedef enum logic [2:0] {
    VIEW_LO_NIB = 3'd0,
    VIEW_HI_NIB = 3'd1,
    VIEW_BYTE   = 3'd2,
    VIEW_LE16   = 3'd3,
    VIEW_BE16   = 3'd4,
    VIEW_LE32   = 3'd5,
    VIEW_BE32   = 3'd6
  } view_e;

  // compare codes; code 7 is reserved and never matches
  typedef enum logic [2:0] {
    OP_EQ     = 3'd0,
    OP_NE     = 3'd1,
    OP_LT     = 3'd2,
    OP_LE     = 3'd3,
    OP_GT     = 3'd4,
    OP_GE     = 3'd5,
    OP_MASKED = 3'd6
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_VALUE_VIEW    = 3'd0,
    CFG_COMPARE_OP    = 3'd1,
    CFG_SOURCE_SELECT = 3'd2,
    CFG_COMPARE_CONST = 3'd3,
    CFG_BIT_MASK      = 3'd4,
    CFG_BASE_ADDRESS  = 3'd5
  } cfg_idx_e;

  // configuration seen by the compare stage
  typedef struct packed {
    view_e              view;
    op_e                op;
    logic               src_b;
    logic [WordW-1:0]   cmp_const;
    logic [MaskW-1:0]   bit_mask;
    logic [WordW-1:0]   base_addr;
  } msvs_cfg_t;

  // compare stage status: match flag and window start offset
  typedef struct packed {
    logic       hit;
    logic [1:0] back;
  } msvs_cmp_t;

  // reset values of the configuration registers
  localparam msvs_cfg_t CfgReset = '{
    view:      VIEW_BYTE,
    op:        OP_EQ,
    src_b:     1'b0,
    cmp_const: '0,
    bit_mask:  8'hFF,
    base_addr: '0
  };

endpackage

### rtl/core/memory_snapshot_value_scanner.sv
// ----------------------------------------------------------------------------
// memory_snapshot_value_scanner
// Sliding-window value scanner over a byte stream of a memory snapshot.
// ----------------------------------------------------------------------------
// The block takes one snapshot byte per clock cycle and keeps taking one per
// cycle as long as the result side does not stall. An accepted byte is shifted
// into the window and captured, together with its address, in the input
// register; the compare stage then forms the view from that register and, on
// a match, loads the window start address into the result register once the
// result register can take it. Bytes that do not match leave no result. A
// result waiting in the output register stalls the input only once the input
// register is also full.
module memory_snapshot_value_scanner #(
  parameter int unsigned ADDR_WIDTH = msvs_pkg::DefAddrW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [msvs_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [msvs_pkg::WordW-1:0]        cfg_wdata_i,
  // byte input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [msvs_pkg::ByteW-1:0]        byte_a_i,
  input  logic [msvs_pkg::ByteW-1:0]        byte_b_i,
  input  logic                              first_byte_i,
  // match output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [msvs_pkg::MatchW-1:0]       match_address_o
);
  import msvs_pkg::*;

  msvs_cfg_t               cfg_q;
  // scan state
  logic [WindowW-1:0]      win_a_q, win_a_d;
  logic [WindowW-1:0]      win_b_q, win_b_d;
  logic [1:0]              fill_q, fill_d;
  logic [ADDR_WIDTH-1:0]   addr_q, addr_d;
  logic [ADDR_WIDTH-1:0]   base_ext;
  // input register
  logic                    s1_valid_q;
  logic [WordW-1:0]        s1_seq_a_q, s1_seq_a_d;
  logic [WordW-1:0]        s1_seq_b_q, s1_seq_b_d;
  logic [1:0]              s1_fill_q, s1_fill_d;
  logic [ADDR_WIDTH-1:0]   s1_addr_q, s1_addr_d;
  // result register
  logic                    out_valid_q;
  logic [MatchW-1:0]       out_addr_q;
  logic [ADDR_WIDTH-1:0]   start_addr;
  logic                    out_ready;
  logic                    in_xfer;
  msvs_cmp_t               cmp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_VALUE_VIEW:    cfg_q.view      <= view_e'(cfg_wdata_i[2:0]);
        CFG_COMPARE_OP:    cfg_q.op        <= op_e'(cfg_wdata_i[2:0]);
        CFG_SOURCE_SELECT: cfg_q.src_b     <= cfg_wdata_i[0];
        CFG_COMPARE_CONST: cfg_q.cmp_const <= cfg_wdata_i;
        CFG_BIT_MASK:      cfg_q.bit_mask  <= cfg_wdata_i[MaskW-1:0];
        CFG_BASE_ADDRESS:  cfg_q.base_addr <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign base_ext   = ADDR_WIDTH'(cfg_q.base_addr);

  // window shift and address count on each input transfer
  always_comb begin
    win_a_d    = first_byte_i ? '0 : win_a_q;
    win_b_d    = first_byte_i ? '0 : win_b_q;
    s1_fill_d  = first_byte_i ? 2'd0 : fill_q;
    s1_addr_d  = first_byte_i ? base_ext : addr_q;
    s1_seq_a_d = {win_a_d, byte_a_i};
    s1_seq_b_d = {win_b_d, byte_b_i};
    fill_d     = (s1_fill_d == 2'd3) ? 2'd3 : s1_fill_d + 2'd1;
    addr_d     = s1_addr_d + ADDR_WIDTH'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_a_q <= '0;
      win_b_q <= '0;
      fill_q  <= '0;
      addr_q  <= '0;
    end else if (in_xfer) begin
      win_a_q <= s1_seq_a_d[WindowW-1:0];
      win_b_q <= s1_seq_b_d[WindowW-1:0];
      fill_q  <= fill_d;
      addr_q  <= addr_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_seq_a_q <= s1_seq_a_d;
      s1_seq_b_q <= s1_seq_b_d;
      s1_fill_q  <= s1_fill_d;
      s1_addr_q  <= s1_addr_d;
    end
  end

  // view and compare
  msvs_compare u_compare (
    .cfg_i    (cfg_q),
    .seq_a_i  (s1_seq_a_q),
    .seq_b_i  (s1_seq_b_q),
    .fill_i   (s1_fill_q),
    .status_o (cmp)
  );

  assign start_addr = s1_addr_q - ADDR_WIDTH'(cmp.back);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q && cmp.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q && cmp.hit) begin
      out_addr_q <= MatchW'(start_addr);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_address_o = out_addr_q;

  // a full input register behind a stalled result must hold off the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input not stalled while both stages are blocked");

  // a start mark restarts the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && first_byte_i |=> fill_q == 2'd1)
    else $error("fill count not restarted by start mark");

  // a start mark restarts the address at the base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && first_byte_i |=> addr_q == $past(base_ext) + ADDR_WIDTH'(1))
    else $error("address not restarted at base");

  // a new result only comes from a loaded input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a captured item");

endmodule

### rtl/core/msvs_compare.sv
// ----------------------------------------------------------------------------
// msvs_compare
// Forms the selected view from a four-byte window and compares it unsigned
// against the constant or the second snapshot's view.
// ----------------------------------------------------------------------------
module msvs_compare (
  input  msvs_pkg::msvs_cfg_t          cfg_i,
  input  logic [msvs_pkg::WordW-1:0]   seq_a_i,
  input  logic [msvs_pkg::WordW-1:0]   seq_b_i,
  input  logic [1:0]                   fill_i,
  output msvs_pkg::msvs_cmp_t          status_o
);
  import msvs_pkg::*;

  logic             view_ok;
  logic             fill_ok;
  logic             hit;
  logic [1:0]       need_m1;
  logic [WordW-1:0] width_mask;
  logic [WordW-1:0] val_a;
  logic [WordW-1:0] val_b;
  logic [WordW-1:0] operand;

  // pick the view out of a window, newest byte in the low bits
  function automatic logic [WordW-1:0] view_value(input view_e v, input logic [WordW-1:0] s);
    logic [WordW-1:0] r;
    unique case (v)
      VIEW_LO_NIB: r = {{(WordW-NibbleW){1'b0}}, s[NibbleW-1:0]};
      VIEW_HI_NIB: r = {{(WordW-NibbleW){1'b0}}, s[ByteW-1:NibbleW]};
      VIEW_BYTE:   r = {{(WordW-ByteW){1'b0}}, s[ByteW-1:0]};
      VIEW_LE16:   r = {{(WordW-2*ByteW){1'b0}}, s[ByteW-1:0], s[2*ByteW-1:ByteW]};
      VIEW_BE16:   r = {{(WordW-2*ByteW){1'b0}}, s[2*ByteW-1:ByteW], s[ByteW-1:0]};
      VIEW_LE32:   r = {s[ByteW-1:0], s[2*ByteW-1:ByteW], s[3*ByteW-1:2*ByteW],
                        s[4*ByteW-1:3*ByteW]};
      default:     r = s;
    endcase
    return r;
  endfunction

  // view width, bytes needed and window fill check
  always_comb begin
    view_ok    = 1'b1;
    fill_ok    = 1'b1;
    need_m1    = 2'd0;
    width_mask = ByteMask;
    unique case (cfg_i.view)
      VIEW_LO_NIB, VIEW_HI_NIB, VIEW_BYTE: begin
        need_m1 = 2'd0;
      end
      VIEW_LE16, VIEW_BE16: begin
        need_m1    = 2'd1;
        width_mask = HalfMask;
        fill_ok    = (fill_i >= 2'd1);
      end
      VIEW_LE32, VIEW_BE32: begin
        need_m1    = 2'd3;
        width_mask = FullMask;
        fill_ok    = (fill_i == 2'd3);
      end
      default: begin
        view_ok = 1'b0;
      end
    endcase
  end

  // operands
  assign val_a   = view_value(cfg_i.view, seq_a_i);
  assign val_b   = view_value(cfg_i.view, seq_b_i);
  assign operand = cfg_i.src_b ? val_b : (cfg_i.cmp_const & width_mask);

  // comparison
  always_comb begin
    unique case (cfg_i.op)
      OP_EQ:     hit = (val_a == operand);
      OP_NE:     hit = (val_a != operand);
      OP_LT:     hit = (val_a < operand);
      OP_LE:     hit = (val_a <= operand);
      OP_GT:     hit = (val_a > operand);
      OP_GE:     hit = (val_a >= operand);
      OP_MASKED: hit = ((val_a & {{(WordW-MaskW){1'b0}}, cfg_i.bit_mask}) == operand);
      default:   hit = 1'b0;
    endcase
  end

  assign status_o.hit  = hit && view_ok && fill_ok;
  assign status_o.back = need_m1;

endmodule

### sim/msvs_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msvs_scan_checker
// Watches the scanner's ports, predicts match addresses and compares them.
// ----------------------------------------------------------------------------
// Keeps its own copy of the configuration registers and of the scan window.
// Every byte transfer updates the window and, on a hit, queues the window's
// start address. Every match transfer is compared with the oldest queued
// address.
module msvs_scan_checker #(
  parameter int unsigned ADDR_WIDTH = msvs_pkg::DefAddrW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msvs_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [msvs_pkg::WordW-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [msvs_pkg::ByteW-1:0]      byte_a_i,
  input  logic [msvs_pkg::ByteW-1:0]      byte_b_i,
  input  logic                            first_byte_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [msvs_pkg::MatchW-1:0]     match_address_i,
  output int unsigned                     err_cnt_o,
  output int unsigned                     pending_o,
  output int unsigned                     bytes_o,
  output int unsigned                     matches_o
);
  import msvs_pkg::*;

  // configuration copy
  logic [2:0]            view_q;
  logic [2:0]            op_q;
  logic                  src_b_q;
  logic [WordW-1:0]      cmp_const_q;
  logic [MaskW-1:0]      bit_mask_q;
  logic [WordW-1:0]      base_q;

  // scan state
  logic [WindowW-1:0]    win_a_q;
  logic [WindowW-1:0]    win_b_q;
  logic [1:0]            fill_q;
  logic [ADDR_WIDTH-1:0] addr_q;

  // window start addresses still to come out
  logic [MatchW-1:0]     expected_addrs[$];

  int unsigned errors;
  int unsigned n_bytes;
  int unsigned n_matches;

  // value the selected view forms from four bytes, oldest in the top byte
  function automatic logic [WordW-1:0] view_value(logic [2:0] view, logic [WordW-1:0] seq);
    logic [ByteW-1:0] cur;
    logic [ByteW-1:0] prv;
    cur = seq[7:0];
    prv = seq[15:8];
    case (view)
      VIEW_LO_NIB: view_value = {28'd0, cur[3:0]};
      VIEW_HI_NIB: view_value = {28'd0, cur[7:4]};
      VIEW_BYTE:   view_value = {24'd0, cur};
      VIEW_LE16:   view_value = {16'd0, cur, prv};
      VIEW_BE16:   view_value = {16'd0, prv, cur};
      VIEW_LE32:   view_value = {seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
      default:     view_value = seq;
    endcase
  endfunction

  // bytes the view needs before it can compare
  function automatic int unsigned view_bytes(logic [2:0] view);
    if (view <= VIEW_BYTE) return 1;
    if (view <= VIEW_BE16) return 2;
    return 4;
  endfunction

  // one snapshot byte through the window and the comparison
  task automatic scan_byte(logic [ByteW-1:0] a, logic [ByteW-1:0] b, logic start);
    logic [WordW-1:0]      seq_a;
    logic [WordW-1:0]      seq_b;
    logic [WordW-1:0]      va;
    logic [WordW-1:0]      vo;
    logic [WordW-1:0]      width_mask;
    logic [ADDR_WIDTH-1:0] start_addr;
    int unsigned           need;
    logic                  hit;
    if (start) begin
      win_a_q = '0;
      win_b_q = '0;
      fill_q  = '0;
      addr_q  = ADDR_WIDTH'(base_q);
    end
    seq_a = {win_a_q, a};
    seq_b = {win_b_q, b};
    need  = view_bytes(view_q);
    hit   = 1'b0;
    // reserved codes and a window not yet full never match
    if (view_q <= VIEW_BE32 && op_q <= OP_MASKED && int'(fill_q) + 1 >= need) begin
      va = view_value(view_q, seq_a);
      width_mask = (need == 1) ? ByteMask : (need == 2) ? HalfMask : FullMask;
      vo = src_b_q ? view_value(view_q, seq_b) : (cmp_const_q & width_mask);
      case (op_q)
        OP_EQ:   hit = (va == vo);
        OP_NE:   hit = (va != vo);
        OP_LT:   hit = (va < vo);
        OP_LE:   hit = (va <= vo);
        OP_GT:   hit = (va > vo);
        OP_GE:   hit = (va >= vo);
        default: hit = ((va & {24'd0, bit_mask_q}) == vo);
      endcase
    end
    if (hit) begin
      start_addr = addr_q - ADDR_WIDTH'(need - 1);
      expected_addrs.push_back(MatchW'(start_addr));
    end
    win_a_q = seq_a[WindowW-1:0];
    win_b_q = seq_b[WindowW-1:0];
    if (fill_q != 2'd3) fill_q = fill_q + 2'd1;
    addr_q = addr_q + ADDR_WIDTH'(1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [MatchW-1:0] want;
    if (!rst_ni) begin
      view_q      = CfgReset.view;
      op_q        = CfgReset.op;
      src_b_q     = CfgReset.src_b;
      cmp_const_q = CfgReset.cmp_const;
      bit_mask_q  = CfgReset.bit_mask;
      base_q      = CfgReset.base_addr;
      win_a_q     = '0;
      win_b_q     = '0;
      fill_q      = '0;
      addr_q      = '0;
      expected_addrs.delete();
      errors      = 0;
      n_bytes     = 0;
      n_matches   = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_VALUE_VIEW:    view_q      = cfg_wdata_i[2:0];
          CFG_COMPARE_OP:    op_q        = cfg_wdata_i[2:0];
          CFG_SOURCE_SELECT: src_b_q     = cfg_wdata_i[0];
          CFG_COMPARE_CONST: cmp_const_q = cfg_wdata_i;
          CFG_BIT_MASK:      bit_mask_q  = cfg_wdata_i[MaskW-1:0];
          CFG_BASE_ADDRESS:  base_q      = cfg_wdata_i;
          default: ;
        endcase
      end
      // match transfer against the oldest expected address
      if (out_valid_i && !out_stall_i) begin
        n_matches++;
        if (expected_addrs.size() == 0) begin
          $display("%0t: match_address expected none actual %h", $time, match_address_i);
          errors++;
        end else begin
          want = expected_addrs.pop_front();
          if (match_address_i !== want) begin
            $display("%0t: match_address expected %h actual %h", $time, want,
                     match_address_i);
            errors++;
          end
        end
      end
      // byte transfer
      if (in_valid_i && !in_stall_i) begin
        n_bytes++;
        scan_byte(byte_a_i, byte_b_i, first_byte_i);
      end
    end
    err_cnt_o <= errors;
    pending_o <= expected_addrs.size();
    bytes_o   <= n_bytes;
    matches_o <= n_matches;
  end

endmodule

### sim/tb_memory_snapshot_value_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_memory_snapshot_value_scanner
// Stimulus and verdict for the memory snapshot value scanner.
// ----------------------------------------------------------------------------
// Runs a few directed scans over views, compare codes, reserved codes and
// address wrap, then random scans under many register settings while both
// sides idle at random, and once holds off the result side long enough for
// the block to stall its input. The checker does all comparing.
module tb_memory_snapshot_value_scanner;
  import msvs_pkg::*;

  localparam logic [2:0]  ViewReserved = 3'd7;
  localparam logic [2:0]  OpReserved   = 3'd7;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned IdleLimit    = 20000;
  localparam int unsigned SetsPerPhase = 10;
  localparam int unsigned BytesPerSet  = 50;
  localparam int unsigned BurstBytes   = 60;
  localparam int unsigned TimeoutNs    = 3_000_000;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i  = '0;
  logic [WordW-1:0]     cfg_wdata_i  = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [ByteW-1:0]     byte_a_i     = '0;
  logic [ByteW-1:0]     byte_b_i     = '0;
  logic                 first_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [MatchW-1:0]    match_address_o;

  int unsigned check_errors;
  int unsigned pending;
  int unsigned n_bytes;
  int unsigned n_matches;
  int unsigned tb_errors   = 0;
  int unsigned n_writes    = 0;
  int unsigned n_settings  = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_off_req = 1'b0;
  logic        hold_done    = 1'b0;
  logic [31:0] cur_const   = '0;

  memory_snapshot_value_scanner u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .byte_a_i,
    .byte_b_i,
    .first_byte_i,
    .out_valid_o,
    .out_stall_i,
    .match_address_o
  );

  msvs_scan_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i      (in_stall_o),
    .byte_a_i,
    .byte_b_i,
    .first_byte_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .match_address_i (match_address_o),
    .err_cnt_o       (check_errors),
    .pending_o       (pending),
    .bytes_o         (n_bytes),
    .matches_o       (n_matches)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // offer one byte and wait for its transfer
  task automatic send_byte(input logic [7:0] a, input logic [7:0] b, input logic fb);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_a_i     <= a;
    byte_b_i     <= b;
    first_byte_i <= fb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop offering, let every expected match out and the pipeline empty
  task automatic wait_idle();
    int unsigned w;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    w = 0;
    while (pending != 0 && w < IdleLimit) begin
      @(posedge clk_i);
      w++;
    end
    if (pending != 0) begin
      $display("%0t: %0d expected match address(es) never came out", $time, pending);
      tb_errors++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    n_writes++;
  endtask

  // full register setting, written back to back while the block is idle
  task automatic apply_cfg(input logic [2:0] view, input logic [2:0] op, input logic src_b,
                           input logic [31:0] k, input logic [7:0] m,
                           input logic [31:0] base);
    wait_idle();
    write_reg(CFG_VALUE_VIEW, 32'(view));
    write_reg(CFG_COMPARE_OP, 32'(op));
    write_reg(CFG_SOURCE_SELECT, 32'(src_b));
    write_reg(CFG_COMPARE_CONST, k);
    write_reg(CFG_BIT_MASK, 32'(m));
    write_reg(CFG_BASE_ADDRESS, base);
    cfg_we_i <= 1'b0;
    cur_const = k;
    n_settings++;
  endtask

  // bytes lean toward values that hit: constant bytes and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'(cur_const >> (8 * $urandom_range(0, 3)));
      1:       return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_cfg();
    logic [2:0]  v;
    logic [2:0]  o;
    logic [31:0] k;
    logic [7:0]  m;
    logic [31:0] base;
    v = ($urandom_range(0, 11) == 0) ? ViewReserved : 3'($urandom_range(0, 6));
    o = ($urandom_range(0, 11) == 0) ? OpReserved : 3'($urandom_range(0, 6));
    // masked equality is meant for the byte view
    if (o == OP_MASKED && $urandom_range(0, 3) != 0) v = VIEW_BYTE;
    case ($urandom_range(0, 3))
      0:       k = '0;
      1:       k = '1;
      2:       k = 32'($urandom_range(0, 31));
      default: k = $urandom;
    endcase
    case ($urandom_range(0, 2))
      0:       m = '0;
      1:       m = '1;
      default: m = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: base = $urandom;
    endcase
    apply_cfg(v, o, 1'($urandom_range(0, 1)), k, m, base);
  endtask

  // one scan, usually opened by a start mark, with occasional restarts
  task automatic scan_set(input int unsigned n);
    logic       fb;
    logic [7:0] a;
    logic [7:0] b;
    fb = ($urandom_range(0, 4) != 0);
    for (int unsigned i = 0; i < n; i++) begin
      a = pick_byte();
      b = $urandom_range(0, 1) ? a : pick_byte();
      send_byte(a, b, (i == 0) ? fb : ($urandom_range(0, 15) == 0));
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 13;
    rx_idle_pct = 71;

    // reset setting, scan without start mark counts from address zero
    send_byte(8'h00, 8'h00, 1'b0);
    send_byte(8'hFF, 8'h00, 1'b0);
    send_byte(8'h00, 8'hFF, 1'b0);

    // 32-bit big endian, window filling and address wrap
    apply_cfg(VIEW_BE32, OP_EQ, 1'b0, 32'h0102_0304, 8'hFF, 32'hFFFF_FFFE);
    send_byte(8'h01, 8'h00, 1'b1);
    send_byte(8'h02, 8'h00, 1'b0);
    send_byte(8'h03, 8'h00, 1'b0);
    send_byte(8'h04, 8'h00, 1'b0);
    send_byte(8'h05, 8'h00, 1'b0);

    // masked equality, constant truncated to a byte
    apply_cfg(VIEW_BYTE, OP_MASKED, 1'b0, 32'hFFFF_FFA0, 8'hF0, 32'h0000_0000);
    send_byte(8'hA5, 8'h00, 1'b1);
    send_byte(8'h5A, 8'h00, 1'b0);
    send_byte(8'hAF, 8'h00, 1'b0);

    // 16-bit little endian against the second snapshot
    apply_cfg(VIEW_LE16, OP_LT, 1'b1, 32'h0000_0000, 8'hFF, 32'h8000_0000);
    send_byte(8'h10, 8'h20, 1'b1);
    send_byte(8'h00, 8'h01, 1'b0);
    send_byte(8'hFF, 8'hFF, 1'b0);

    // low nibble against a constant above 15
    apply_cfg(VIEW_LO_NIB, OP_NE, 1'b0, 32'h0000_001F, 8'hFF, 32'h0000_0100);
    send_byte(8'h0F, 8'h00, 1'b1);
    send_byte(8'hFF, 8'h00, 1'b0);

    // high nibble against the second snapshot
    apply_cfg(VIEW_HI_NIB, OP_GT, 1'b1, 32'h0000_0000, 8'h00, 32'h0000_0200);
    send_byte(8'hF0, 8'hE0, 1'b1);
    send_byte(8'h00, 8'h10, 1'b0);

    // 32-bit little endian against the second snapshot
    apply_cfg(VIEW_LE32, OP_LE, 1'b1, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF);
    send_byte(8'h11, 8'h11, 1'b1);
    send_byte(8'h22, 8'h22, 1'b0);
    send_byte(8'h33, 8'h33, 1'b0);
    send_byte(8'h44, 8'h45, 1'b0);

    // reserved view, then reserved compare code
    apply_cfg(ViewReserved, OP_GE, 1'b0, 32'h0000_0000, 8'hFF, 32'h0000_0000);
    send_byte(8'h12, 8'h00, 1'b1);
    apply_cfg(VIEW_BE16, OpReserved, 1'b0, 32'h0000_0000, 8'hFF, 32'h0000_0000);
    send_byte(8'h34, 8'h00, 1'b1);

    // random scans under three idling regimes
    for (int unsigned ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 2) begin
        // every byte matches while the result side holds off
        apply_cfg(VIEW_BYTE, OP_GE, 1'b0, 32'h0000_0000, 8'hFF, 32'h0000_1000);
        hold_off_req = 1'b1;
        for (int unsigned i = 0; i < BurstBytes; i++)
          send_byte(8'($urandom), 8'($urandom), i == 0);
      end
      for (int unsigned s = 0; s < SetsPerPhase; s++) begin
        random_cfg();
        scan_set(BytesPerSet);
      end
    end

    wait_idle();
    $display("scanned %0d bytes and checked %0d match addresses", n_bytes, n_matches);
    $display("%0d register writes over %0d settings, one long result hold-off",
             n_writes, n_settings);
    if (check_errors == 0 && tb_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### memory_snapshot_value_scanner.f
rtl/core/msvs_pkg.sv
rtl/core/msvs_compare.sv
rtl/core/memory_snapshot_value_scanner.sv
sim/msvs_scan_checker.sv
sim/tb_memory_snapshot_value_scanner.sv
